// ===== rtl/dds_pkg.sv =====
// Shared constants and transaction types for the dense shortest-path unit.
// No dependencies; imported by dds_search, dense_dijkstra_shortest_paths_unit and its testbench.
`default_nettype none

package dds_pkg;

  // Graph size and weight width
  localparam int NODES       = 8;
  localparam int WEIGHT_BITS = 16;

  localparam int NODE_BITS = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ENTRIES   = NODES * NODES;
  localparam int POS_BITS  = $clog2(ENTRIES);
  // counter that can also hold NODES itself
  localparam int CNT_BITS  = NODE_BITS + 1;

  // Distances saturate at the top of the 19-bit range
  localparam int DIST_BITS = 19;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam int SUM_BITS  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

  // Reporting limit
  localparam int REPORT_MAX   = 8;
  localparam int REPORT_LIMIT = (NODES < REPORT_MAX) ? NODES : REPORT_MAX;

  // Fixed port widths
  localparam int EDGE_BITS       = 16;
  localparam int VERTEX_BITS     = 3;
  localparam int SOURCE_BITS     = 3;
  localparam int NODE_COUNT_BITS = 4;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_NODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT  = 2'd1;

  // Weight memory write request
  typedef struct packed {
    logic                   en;
    logic [POS_BITS-1:0]    addr;
    logic [WEIGHT_BITS-1:0] data;
  } dds_wr_t;

  // Run start command
  typedef struct packed {
    logic                   start;
    logic [SOURCE_BITS-1:0] source;
    logic [CNT_BITS-1:0]    count;
  } dds_ctrl_t;

  // One reported vertex
  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex;
    logic [DIST_BITS-1:0]   path_length;
    logic                   reachable;
    logic                   last_result;
  } dds_result_t;

endpackage

`default_nettype wire

// ===== rtl/dds_search.sv =====
// Weight memory plus the search sequencer: scan for the next vertex, relax
// its row, then stream out the results. Depends on dds_pkg.
`default_nettype none

module dds_search (
  input  wire                       clk,
  input  wire                       rst,
  input  wire dds_pkg::dds_wr_t     wr,
  input  wire dds_pkg::dds_ctrl_t   ctrl,
  output logic                      idle,
  output logic                      rep_valid,
  input  wire                       rep_ready,
  output dds_pkg::dds_result_t      rep
);
  import dds_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_RELAX,
    S_REPORT
  } state_t;

  state_t state;

  // Weight memory, one write and one registered read port
  logic [WEIGHT_BITS-1:0] mem [ENTRIES];
  logic [WEIGHT_BITS-1:0] rdata;
  logic [POS_BITS-1:0]    rd_addr;

  // Per-vertex state
  logic [DIST_BITS-1:0] best_dist [NODES];
  logic [NODES-1:0]     inf;
  logic [NODES-1:0]     done;

  // Sequencer
  logic [CNT_BITS-1:0]  cnt;
  logic [NODE_BITS-1:0] round;
  logic [CNT_BITS-1:0]  count_r;

  // Running best candidate of the scan
  logic                 have;
  logic [NODE_BITS-1:0] ch_idx;
  logic                 ch_inf;
  logic [DIST_BITS-1:0] ch_d;

  // Row under relaxation
  logic [NODE_BITS-1:0] cur_m;
  logic [DIST_BITS-1:0] dist_m;
  logic                 p_valid;
  logic [NODE_BITS-1:0] p_k;

  logic [NODE_BITS-1:0] v;
  logic                 take;
  logic                 last_scan;
  logic [NODE_BITS-1:0] nx_idx;
  logic                 nx_inf;
  logic [DIST_BITS-1:0] nx_d;
  logic                 issue;
  logic [SUM_BITS-1:0]  sum_full;
  logic [DIST_BITS-1:0] sum_sat;
  logic                 improve;
  logic                 round_end;
  logic                 last_round;
  logic                 rep_last;

  // Scan step: least distance, ties to the highest index, unreached on top
  always_comb begin
    v    = cnt[NODE_BITS-1:0];
    take = 1'b0;
    if (!done[v]) begin
      if (!have) begin
        take = 1'b1;
      end else if (inf[v]) begin
        take = ch_inf;
      end else begin
        take = ch_inf || (best_dist[v] <= ch_d);
      end
    end
    nx_idx    = take ? v : ch_idx;
    nx_inf    = take ? inf[v] : ch_inf;
    nx_d      = take ? best_dist[v] : ch_d;
    last_scan = (state == S_PICK) && (int'(cnt) == NODES - 1);
  end

  // Relax step: saturating add and compare against the stored distance
  always_comb begin
    issue    = (state == S_RELAX) && (int'(cnt) < NODES);
    rd_addr  = POS_BITS'(int'(cur_m) * NODES + int'(cnt[NODE_BITS-1:0]));
    sum_full = SUM_BITS'(dist_m) + SUM_BITS'(rdata);
    sum_sat  = (sum_full > SUM_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum_full);
    improve  = p_valid && !done[p_k] && (rdata != '0) &&
               (inf[p_k] || (sum_sat < best_dist[p_k]));
    // relax pass ends once the last column's read data is consumed
    round_end  = (state == S_RELAX) && p_valid && (int'(p_k) == NODES - 1);
    last_round = (int'(round) == NODES - 1);
  end

  // Result stream
  always_comb begin
    idle            = (state == S_IDLE);
    rep_valid       = (state == S_REPORT);
    rep_last        = (CNT_BITS'(cnt + 1'b1) == count_r);
    rep.vertex      = VERTEX_BITS'(cnt);
    rep.path_length = inf[cnt[NODE_BITS-1:0]] ? '0 : best_dist[cnt[NODE_BITS-1:0]];
    rep.reachable   = !inf[cnt[NODE_BITS-1:0]];
    rep.last_result = rep_last;
  end

  // Weight memory
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[rd_addr];
  end

  // Sequencer and vertex state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_valid <= 1'b0;
      have    <= 1'b0;
      cnt     <= '0;
      round   <= '0;
      count_r <= '0;
      inf     <= '1;
      done    <= '0;
    end else begin
      p_valid <= issue;
      if (issue) begin
        p_k <= cnt[NODE_BITS-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            for (int i = 0; i < NODES; i++) begin
              inf[i]       <= !(int'(ctrl.source) == i);
              done[i]      <= 1'b0;
              best_dist[i] <= '0;
            end
            count_r <= ctrl.count;
            cnt     <= '0;
            round   <= '0;
            have    <= 1'b0;
            state   <= S_PICK;
          end
        end
        S_PICK: begin
          ch_idx <= nx_idx;
          ch_inf <= nx_inf;
          ch_d   <= nx_d;
          if (last_scan) begin
            done[nx_idx] <= 1'b1;
            cur_m        <= nx_idx;
            dist_m       <= nx_d;
            cnt          <= '0;
            have         <= 1'b0;
            if (!nx_inf) begin
              state <= S_RELAX;
            end else if (last_round) begin
              // unreached pick closes the last round with no relax pass
              state <= (count_r == '0) ? S_IDLE : S_REPORT;
            end else begin
              round <= round + 1'b1;
            end
          end else begin
            have <= have | take;
            cnt  <= cnt + 1'b1;
          end
        end
        S_RELAX: begin
          // close a round: next scan, or once every vertex is done the report (idle if the report count is zero)
          if (round_end) begin
            cnt <= '0;
            if (last_round) begin
              state <= (count_r == '0) ? S_IDLE : S_REPORT;
            end else begin
              round <= round + 1'b1;
              state <= S_PICK;
            end
          end else if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (improve) begin
            best_dist[p_k] <= sum_sat;
            inf[p_k]       <= 1'b0;
          end
        end
        S_REPORT: begin
          if (rep_ready) begin
            cnt <= cnt + 1'b1;
            if (rep_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // each finished round has marked exactly one vertex visited
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |-> $countones(done) == int'(round))
    else $error("visited count out of step with round");

  // only a visited, reached vertex has its row relaxed
  a_relax_row: assert property (@(posedge clk) disable iff (rst)
    state == S_RELAX |-> done[cur_m] && !inf[cur_m])
    else $error("relaxing an unvisited or unreached row");

  // memory read data is consumed only inside a relax pass
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> state == S_RELAX)
    else $error("relax stage active outside relax");

  // no result beyond the report count
  a_rep_count: assert property (@(posedge clk) disable iff (rst)
    rep_valid |-> cnt < count_r)
    else $error("result index past report count");
`endif

endmodule

`default_nettype wire

// ===== rtl/dense_dijkstra_shortest_paths_unit.sv =====
// Top level: configuration registers, matrix load, output register.
// Depends on dds_pkg and dds_search.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_ready  | edge_weight, last_entry
//  out      | out_valid / out_ready| vertex, path_length, reachable, last_result
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A plain matrix entry is stored in the weight memory. The entry with last_entry
// set starts a run of NODES rounds; each round is a scan of every vertex by the
// shared compare unit plus, for a reached vertex, a pass over its row through the
// weight memory's read port and the shared adder; then the results stream out,
// held while out_ready is low. in_ready is low for the whole run and its report.
// Synchronous active-high reset; the weight memory is not cleared.
`default_nettype none

module dense_dijkstra_shortest_paths_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [dds_pkg::EDGE_BITS-1:0]        edge_weight,
  input  wire                                  last_entry,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [dds_pkg::VERTEX_BITS-1:0]      vertex,
  output logic [dds_pkg::DIST_BITS-1:0]        path_length,
  output logic                                 reachable,
  output logic                                 last_result,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [dds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire  [dds_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import dds_pkg::*;

  logic [SOURCE_BITS-1:0]     source_node;
  logic [NODE_COUNT_BITS-1:0] node_count;
  logic [POS_BITS-1:0]        load_position;
  logic [CNT_BITS-1:0]        rep_count;

  dds_wr_t     wr;
  dds_ctrl_t   ctrl;
  dds_result_t rep;
  logic        idle;
  logic        rep_valid;
  logic        rep_ready;
  logic        in_take;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_node <= '0;
      node_count  <= NODE_COUNT_BITS'(REPORT_MAX);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SOURCE_NODE: source_node <= cfg_data[SOURCE_BITS-1:0];
        CFG_NODE_COUNT:  node_count  <= cfg_data[NODE_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Report count clamped to what the block can report
  always_comb begin
    if (int'(node_count) > REPORT_LIMIT) begin
      rep_count = CNT_BITS'(REPORT_LIMIT);
    end else begin
      rep_count = CNT_BITS'(node_count);
    end
  end

  // Matrix load
  assign in_ready = idle;
  assign in_take  = in_valid && idle;

  always_comb begin
    wr.en       = in_take;
    wr.addr     = load_position;
    wr.data     = WEIGHT_BITS'(edge_weight);
    ctrl.start  = in_take && last_entry;
    ctrl.source = source_node;
    ctrl.count  = rep_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
    end else if (in_take) begin
      if (last_entry || (int'(load_position) == ENTRIES - 1)) begin
        load_position <= '0;
      end else begin
        load_position <= load_position + 1'b1;
      end
    end
  end

  dds_search u_search (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .ctrl      (ctrl),
    .idle      (idle),
    .rep_valid (rep_valid),
    .rep_ready (rep_ready),
    .rep       (rep)
  );

  // Output register
  assign rep_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rep_ready) begin
      out_valid <= rep_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_ready && rep_valid) begin
      vertex      <= rep.vertex;
      path_length <= rep.path_length;
      reachable   <= rep.reachable;
      last_result <= rep.last_result;
    end
  end

endmodule

`default_nettype wire

// ===== verif/dense_dijkstra_shortest_paths_unit_tb.sv =====
// Self-checking testbench for dense_dijkstra_shortest_paths_unit: streams weight
// matrices, predicts every reported vertex distance and checks each result.
// Depends on dds_pkg and the unit's RTL.
`default_nettype none

module dense_dijkstra_shortest_paths_unit_tb;
  import dds_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int TIMEOUT_TICKS = 3_000_000;
  // worst-case search plus report, with margin
  localparam int SETTLE_CYCLES = 2 * NODES * NODES + 2 * NODES + 16;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int MAX_REPORTS   = 10;

  // indexes the block does not decode
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  bit clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [EDGE_BITS-1:0] edge_weight;
  logic last_entry;
  logic out_valid;
  logic out_ready;
  logic [VERTEX_BITS-1:0] vertex;
  logic [DIST_BITS-1:0] path_length;
  logic reachable;
  logic last_result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  dense_dijkstra_shortest_paths_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .edge_weight(edge_weight),
    .last_entry(last_entry),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .vertex(vertex),
    .path_length(path_length),
    .reachable(reachable),
    .last_result(last_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block's matrix, load pointer and registers
  logic [WEIGHT_BITS-1:0] weight_copy [ENTRIES];
  int                     load_ptr;
  logic [SOURCE_BITS-1:0] source_reg;
  logic [NODE_COUNT_BITS-1:0] count_reg;

  // Distances still owed by the block, oldest first
  dds_result_t pending_distances [$];

  int errors;
  int tx_idle_pct;
  int rx_stall_pct;

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #TIMEOUT_TICKS;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Register file mirror; unknown indexes are ignored by the block
  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_SOURCE_NODE: source_reg = data[SOURCE_BITS-1:0];
      CFG_NODE_COUNT:  count_reg  = data[NODE_COUNT_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Dijkstra over the shadow matrix; queues one result per reported vertex
  function automatic void solve_paths();
    int unsigned best_len [NODES];
    bit          unreached [NODES];
    bit          visited [NODES];
    int          pick;
    bit          have;
    bit          pick_unreached;
    int unsigned pick_d;
    int unsigned w;
    int unsigned sum;
    int          shown;
    dds_result_t r;
    for (int k = 0; k < NODES; k++) begin
      best_len[k] = 0;
      unreached[k] = 1'b1;
      visited[k] = 1'b0;
    end
    if (source_reg < NODES) unreached[source_reg] = 1'b0;
    for (int round = 0; round < NODES; round++) begin
      // least distance wins, ties go to the higher index, unreached last
      pick = 0;
      have = 1'b0;
      pick_unreached = 1'b1;
      pick_d = 0;
      for (int v = 0; v < NODES; v++) begin
        if (visited[v]) continue;
        if (have && unreached[v] && !pick_unreached) continue;
        if (have && !unreached[v] && !pick_unreached && best_len[v] > pick_d) continue;
        have = 1'b1;
        pick = v;
        pick_unreached = unreached[v];
        pick_d = best_len[v];
      end
      visited[pick] = 1'b1;
      if (unreached[pick]) continue;
      // relax outgoing edges of the picked vertex
      for (int k = 0; k < NODES; k++) begin
        w = weight_copy[pick * NODES + k];
        if (visited[k] || w == 0) continue;
        sum = best_len[pick] + w;
        if (sum > DIST_MAX) sum = DIST_MAX;
        if (unreached[k] || sum < best_len[k]) begin
          best_len[k] = sum;
          unreached[k] = 1'b0;
        end
      end
    end
    shown = (count_reg < REPORT_LIMIT) ? count_reg : REPORT_LIMIT;
    for (int k = 0; k < shown; k++) begin
      r.vertex      = k[VERTEX_BITS-1:0];
      r.path_length = unreached[k] ? '0 : best_len[k][DIST_BITS-1:0];
      r.reachable   = !unreached[k];
      r.last_result = (k + 1 == shown);
      pending_distances.push_back(r);
    end
  endfunction

  // One accepted matrix entry
  function automatic void take_entry(input logic [EDGE_BITS-1:0] w, input logic last);
    weight_copy[load_ptr] = w[WEIGHT_BITS-1:0];
    if (!last) begin
      load_ptr = (load_ptr + 1) % ENTRIES;
    end else begin
      load_ptr = 0;
      solve_paths();
    end
  endfunction

  // Send one matrix entry; valid may stay high into the next call
  task automatic send_entry(input logic [EDGE_BITS-1:0] w, input logic last);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    edge_weight <= w;
    last_entry  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_entry(w, last);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block idle: all results back, then a full search time for silent runs
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [EDGE_BITS-1:0] rand_weight();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return '0;
    if (pick < 7) return EDGE_BITS'($urandom_range(20, 1));
    return EDGE_BITS'($urandom_range(65535));
  endfunction

  // Output side: random backpressure, change at falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Result checker
  dds_result_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_distances.size() == 0) begin
        flag_error($sformatf("unexpected result: vertex=%0d len=%0d reach=%0b last=%0b",
                             vertex, path_length, reachable, last_result));
      end else begin
        want = pending_distances.pop_front();
        if (vertex !== want.vertex || path_length !== want.path_length ||
            reachable !== want.reachable || last_result !== want.last_result) begin
          flag_error($sformatf({"mismatch: expected vertex=%0d len=%0d reach=%0b last=%0b,",
                                " got vertex=%0d len=%0d reach=%0b last=%0b"},
                               want.vertex, want.path_length, want.reachable,
                               want.last_result, vertex, path_length, reachable,
                               last_result));
        end
      end
    end
  end

  // Full load with reset registers: a 65535-weight chain 0->1->..->7
  task automatic test_matrix_load();
    logic [EDGE_BITS-1:0] w;
    for (int pos = 0; pos < ENTRIES; pos++) begin
      w = (pos % NODES == pos / NODES + 1) ? 16'hFFFF : 16'h0000;
      if (pos == 2 * NODES + 5) w = 16'd1;
      send_entry(w, pos == ENTRIES - 1);
    end
  endtask

  // Row 0 rewritten: equal distances to 1 and 2, a cheap branch to 3
  task automatic test_tie_break();
    logic [EDGE_BITS-1:0] row [NODES];
    row = '{16'd0, 16'd5, 16'd5, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0};
    wait_idle();
    for (int c = 0; c < NODES; c++) send_entry(row[c], c == NODES - 1);
  endtask

  // Source at the chain end: nothing else is reachable
  task automatic test_isolated_source();
    wait_idle();
    write_reg(CFG_SOURCE_NODE, {5'b10101, 3'd7});
    send_entry(16'h0000, 1'b1);
    wait_idle();
    write_reg(CFG_SOURCE_NODE, {5'b01010, 3'd0});
  endtask

  // Report count extremes, including zero and clamped values
  task automatic test_report_count();
    logic [NODE_COUNT_BITS-1:0] counts [4];
    counts = '{4'd0, 4'd1, 4'd15, 4'd8};
    wait_idle();
    write_reg(CFG_SPARE_LO, 8'hFF);
    write_reg(CFG_SPARE_HI, 8'h00);
    foreach (counts[i]) begin
      wait_idle();
      write_reg(CFG_NODE_COUNT, {4'($urandom_range(15)), counts[i]});
      // self loop on the source
      send_entry(16'hFFFF, 1'b1);
    end
  endtask

  // More entries than the matrix holds: the load pointer wraps
  task automatic test_wrap_around();
    int len;
    wait_idle();
    len = ENTRIES + $urandom_range(8, 2);
    for (int i = 0; i < len; i++) send_entry(rand_weight(), i == len - 1);
  endtask

  // Random graph updates with random settings between runs
  task automatic test_random_graphs(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      if ($urandom_range(1)) write_reg(CFG_SOURCE_NODE, 8'($urandom_range(255)));
      if ($urandom_range(1)) begin
        pick = $urandom_range(9);
        if (pick == 0) len = 0;
        else if (pick == 1) len = $urandom_range(15, 9);
        else len = $urandom_range(8, 1);
        write_reg(CFG_NODE_COUNT, {4'($urandom_range(15)), 4'(len)});
      end
      len = ($urandom_range(99) < 12) ? $urandom_range(ENTRIES, 11) : $urandom_range(10, 1);
      // keep the total near the requested item count
      if (len > n_items - sent) len = n_items - sent;
      for (int i = 0; i < len; i++) send_entry(rand_weight(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    errors      = 0;
    load_ptr    = 0;
    source_reg  = '0;
    count_reg   = 4'd8;
    tx_idle_pct = 16;
    rx_stall_pct = 49;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    edge_weight <= '0;
    last_entry  <= 1'b0;
    out_ready   <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_matrix_load();
    test_tie_break();
    test_isolated_source();
    test_report_count();
    test_wrap_around();
    test_random_graphs(6);
    tx_idle_pct  = 49;
    rx_stall_pct = 16;
    test_random_graphs(6);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_random_graphs(6);

    // drain, then let any trailing activity show up
    @(negedge clk);
    in_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_distances.size() != 0; i++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_distances.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", pending_distances.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== dense_dijkstra_shortest_paths_unit.f =====
rtl/dds_pkg.sv
rtl/dds_search.sv
rtl/dense_dijkstra_shortest_paths_unit.sv
verif/dense_dijkstra_shortest_paths_unit_tb.sv
